### hdl/odak_pkg.sv
// ----------------------------------------------------------------------------
// odak_pkg
// Shared widths, constants and types of the omni drive kinematics block.
// ----------------------------------------------------------------------------
package odak_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned CFG_W    = 31;
   localparam int unsigned WIDE_W   = 66;
   localparam int unsigned CSR_AW   = 2;

   localparam logic [30:0] K_HALF_SQRT3 = 31'd1859775393;
   localparam logic [30:0] K_INV_SQRT3  = 31'd1239850262;

   localparam logic [CSR_AW-1:0] REG_MAX_DELTA = 2'd0;
   localparam logic [CSR_AW-1:0] REG_CIRC      = 2'd1;
   localparam logic [CSR_AW-1:0] REG_RADIUS    = 2'd2;

   localparam logic [CFG_W-1:0] CFG_RESET = 31'd65536;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SPIN,
      ST_XPART,
      ST_CMD_A,
      ST_CMD_B,
      ST_CMD_C,
      ST_DIFF,
      ST_STEP_A,
      ST_STEP_B,
      ST_STEP_C,
      ST_FK_X,
      ST_FK_X2,
      ST_FK_Y,
      ST_FK_Y2,
      ST_FK_W,
      ST_FK_W2,
      ST_OUT
   } state_type;

   // bit-serial multiplier/divider command
   typedef struct packed {
      logic        mul_go;
      logic        div_go;
   } unit_cmd_type;

   // saturate a sign and magnitude to signed 32 bits
   function automatic logic [DATA_W-1:0] sat_signed(input logic neg,
                                                    input logic [WIDE_W-1:0] m);
      logic [DATA_W-1:0] r;
      if (neg) begin
         if (m >= 66'h80000000) r = 32'h80000000;
         else r = DATA_W'(~m[DATA_W-1:0] + 32'd1);
      end else begin
         if (m > 66'h7FFFFFFF) r = 32'h7FFFFFFF;
         else r = m[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

### hdl/odak_mul.sv
// ----------------------------------------------------------------------------
// odak_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module odak_mul
   import odak_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] op_a,
   input  logic [CFG_W:0]    op_b,
   output logic              done,
   output logic [WIDE_W-1:0] product
);

   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [WIDE_W-1:0] mcand_ff, mcand_in;
   logic [CFG_W:0]    mplier_ff, mplier_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // shift-and-add, one bit of op_b per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = op_a;
         mplier_in = op_b;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = {mcand_ff[WIDE_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[CFG_W:1]};
         cnt_in    = cnt_ff + 6'd1;
         if (cnt_ff == 6'(CFG_W)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### hdl/odak_div.sv
// ----------------------------------------------------------------------------
// odak_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module odak_div
   import odak_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] dividend,
   input  logic [WIDE_W-1:0] divisor,
   output logic              done,
   output logic [WIDE_W-1:0] quotient
);

   logic [WIDE_W-1:0] quo_ff, quo_in;
   logic [WIDE_W-1:0] rem_ff, rem_in;
   logic [WIDE_W-1:0] den_ff, den_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WIDE_W:0]   trial;

   // shift in one dividend bit and subtract when it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WIDE_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = WIDE_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDE_W-1:0];
            quo_in = {quo_ff[WIDE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(WIDE_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/omni_drive_accel_limited_kinematics.sv
// ----------------------------------------------------------------------------
// omni_drive_accel_limited_kinematics
// Three-wheel omni drive kinematics with a per-tick wheel speed change limit.
// ----------------------------------------------------------------------------
// Use: each req_ word is one control tick carrying a commanded body velocity
// (vx, vy, omega). The block computes three wheel speeds, limits their change
// against the stored speeds, stores them and returns one rsp_ word with the
// new wheel speeds and the forward-kinematic body velocity.
// Registers are to be written on the csr_ channel only while the block is
// idle; the block itself does not enforce this. One word at a time goes
// through one bit-serial multiplier and one bit-serial divider; a new req_
// word is not taken before the last one is through. A word takes 12
// passes; when the change limit scales the step it takes 18 passes.
// A zero circumference or radius skips divides and shortens this.
// The divider is the pacing unit.
// Reset clears the stored wheel speeds to zero and the registers to 1.0.
// A result waits in the output register while rsp_tready is low; the next
// req_ word is taken once the sequencer has handed its result over.
// ----------------------------------------------------------------------------
module omni_drive_accel_limited_kinematics
   import odak_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // target_vx, target_vy, target_omega
   input  logic [95:0]        req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // wheel_a_rps, wheel_b_rps, wheel_c_rps, body_vx, body_vy, body_omega
   output logic [191:0]       rsp_tdata,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_AW-1:0]  csr_index,
   input  logic [CFG_W-1:0]   csr_data
);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  lim_ff, circ_ff, rad_ff;
   logic signed [DATA_W-1:0] vx_ff, vy_ff, om_ff;
   logic signed [DATA_W-1:0] vx_in, vy_in, om_in;
   logic [DATA_W-1:0] st_ff [3];
   logic [DATA_W-1:0] st_in [3];
   logic [DATA_W-1:0] cmd_ff [3];
   logic [DATA_W-1:0] cmd_in [3];
   logic [WIDE_W-1:0] a_ff [3];
   logic [WIDE_W-1:0] a_in [3];
   logic [2:0]        neg_ff, neg_in;
   logic [WIDE_W-1:0] spin_ff, spin_in;
   logic              spin_neg_ff, spin_neg_in;
   logic [WIDE_W-1:0] xp_ff, xp_in;
   logic              xp_neg_ff, xp_neg_in;
   logic [WIDE_W-1:0] mx_ff, mx_in;
   logic [WIDE_W-1:0] tmp_ff, tmp_in;
   logic              tneg_ff, tneg_in;
   logic [DATA_W-1:0] bo_ff [3];
   logic [DATA_W-1:0] bo_in [3];
   logic              phase_ff, phase_in;
   logic              rv_ff, rv_in;
   logic [191:0]      rd_ff, rd_in;

   unit_cmd_type      ucmd;
   logic [WIDE_W-1:0] mul_a, mul_p, div_n, div_d, div_q;
   logic [CFG_W:0]    mul_b;
   logic              mul_done, div_done;

   odak_mul u_mul (
      .clock(clock), .reset(reset), .start(ucmd.mul_go),
      .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(mul_p)
   );

   odak_div u_div (
      .clock(clock), .reset(reset), .start(ucmd.div_go),
      .dividend(div_n), .divisor(div_d), .done(div_done), .quotient(div_q)
   );

   // signed 67-bit helpers and values held as sign and 66-bit magnitude
   logic signed [WIDE_W:0] s_num;
   logic              s_neg;
   logic [WIDE_W-1:0] s_mag;
   logic signed [WIDE_W:0] sp_s, xp_s, hy_s;
   logic signed [WIDE_W:0] dd;
   logic [1:0]        widx;
   logic signed [WIDE_W:0] nv;
   logic signed [WIDE_W:0] s0, s1, s2;
   logic              all_below;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff  <= CFG_RESET;
         circ_ff <= CFG_RESET;
         rad_ff  <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MAX_DELTA: lim_ff  <= csr_data;
            REG_CIRC:      circ_ff <= csr_data;
            REG_RADIUS:    rad_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer: next state, unit commands and datapath updates
   always_comb begin
      state_in    = state_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      om_in       = om_ff;
      st_in       = st_ff;
      cmd_in      = cmd_ff;
      a_in        = a_ff;
      neg_in      = neg_ff;
      spin_in     = spin_ff;
      spin_neg_in = spin_neg_ff;
      xp_in       = xp_ff;
      xp_neg_in   = xp_neg_ff;
      mx_in       = mx_ff;
      tmp_in      = tmp_ff;
      tneg_in     = tneg_ff;
      bo_in       = bo_ff;
      phase_in    = phase_ff;
      rv_in       = rv_ff;
      rd_in       = rd_ff;
      ucmd        = '0;
      mul_a       = '0;
      mul_b       = '0;
      div_n       = '0;
      div_d       = {35'd0, circ_ff};
      s_num       = '0;
      widx        = 2'd0;
      nv          = '0;
      dd          = '0;
      all_below   = 1'b0;
      sp_s = spin_neg_ff ? -$signed({1'b0, spin_ff}) : $signed({1'b0, spin_ff});
      xp_s = xp_neg_ff ? -$signed({1'b0, xp_ff}) : $signed({1'b0, xp_ff});
      hy_s = (67'(vy_ff)) <<< 15;
      s0 = 67'($signed(st_ff[0]));
      s1 = 67'($signed(st_ff[1]));
      s2 = 67'($signed(st_ff[2]));
      s_neg = 1'b0;
      s_mag = '0;

      if (rv_ff && rsp_tready) rv_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               vx_in    = req_tdata[31:0];
               vy_in    = req_tdata[63:32];
               om_in    = req_tdata[95:64];
               phase_in = 1'b0;
               state_in = ST_SPIN;
            end
         end
         // radius * |omega|
         ST_SPIN: begin
            mul_a = WIDE_W'(om_ff[31] ? 33'(-34'(om_ff)) : 33'(om_ff));
            mul_b = {1'b0, rad_ff};
            if (!phase_ff) begin
               ucmd.mul_go = 1'b1;
               phase_in    = 1'b1;
            end else if (mul_done) begin
               spin_in     = mul_p;
               spin_neg_in = om_ff[31] && (mul_p != '0);
               phase_in    = 1'b0;
               state_in    = ST_XPART;
            end
         end
         // round(|vx| * K / 2^15)
         ST_XPART: begin
            mul_a = WIDE_W'(vx_ff[31] ? 33'(-34'(vx_ff)) : 33'(vx_ff));
            mul_b = {1'b0, K_HALF_SQRT3};
            if (!phase_ff) begin
               ucmd.mul_go = 1'b1;
               phase_in    = 1'b1;
            end else if (mul_done) begin
               xp_in     = (mul_p + 66'd16384) >> 15;
               xp_neg_in = vx_ff[31];
               phase_in  = 1'b0;
               state_in  = ST_CMD_A;
            end
         end
         // rounded division of each wheel surface speed by circumference
         ST_CMD_A, ST_CMD_B, ST_CMD_C: begin
            case (state_ff)
               ST_CMD_A: begin s_num = hy_s + xp_s + sp_s; widx = 2'd0; end
               ST_CMD_B: begin s_num = hy_s - xp_s + sp_s; widx = 2'd1; end
               default:  begin s_num = sp_s - ((67'(vy_ff)) <<< 16); widx = 2'd2; end
            endcase
            s_neg = s_num[WIDE_W];
            s_mag = s_neg ? WIDE_W'(-s_num) : WIDE_W'(s_num);
            div_n = s_mag + WIDE_W'(circ_ff >> 1);
            if (circ_ff == '0) begin
               cmd_in[widx] = (s_mag == '0) ? '0 : sat_signed(s_neg, '1);
               state_in = (state_ff == ST_CMD_A) ? ST_CMD_B :
                          (state_ff == ST_CMD_B) ? ST_CMD_C : ST_DIFF;
            end else if (!phase_ff) begin
               ucmd.div_go = 1'b1;
               phase_in    = 1'b1;
            end else if (div_done) begin
               cmd_in[widx] = sat_signed(s_neg, div_q);
               phase_in     = 1'b0;
               state_in = (state_ff == ST_CMD_A) ? ST_CMD_B :
                          (state_ff == ST_CMD_B) ? ST_CMD_C : ST_DIFF;
            end
         end
         // changes, their magnitudes and the largest; clear the sub-step flags
         ST_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               dd = 67'($signed(cmd_ff[i])) - 67'($signed(st_ff[i]));
               neg_in[i] = dd[WIDE_W];
               a_in[i]   = dd[WIDE_W] ? WIDE_W'(-dd) : WIDE_W'(dd);
            end
            mx_in = a_in[0];
            if (a_in[1] > mx_in) mx_in = a_in[1];
            if (a_in[2] > mx_in) mx_in = a_in[2];
            all_below = (a_in[0] < WIDE_W'(lim_ff)) && (a_in[1] < WIDE_W'(lim_ff))
                        && (a_in[2] < WIDE_W'(lim_ff));
            if (all_below) begin
               st_in    = cmd_ff;
               state_in = ST_FK_X;
            end else if (mx_in == '0) begin
               state_in = ST_FK_X;
            end else begin
               state_in = ST_STEP_A;
            end
            phase_in    = 1'b0;
            tneg_in     = 1'b0;
            spin_neg_in = 1'b0;
         end
         // scaled step: (a*lim + mx/2) / mx, multiply then divide
         ST_STEP_A, ST_STEP_B, ST_STEP_C: begin
            widx  = (state_ff == ST_STEP_A) ? 2'd0 :
                    (state_ff == ST_STEP_B) ? 2'd1 : 2'd2;
            mul_a = a_ff[widx];
            mul_b = {1'b0, lim_ff};
            div_n = tmp_ff;
            div_d = mx_ff;
            if (!phase_ff && !tneg_ff) begin
               ucmd.mul_go = 1'b1;
               tneg_in     = 1'b1;
            end else if (!phase_ff && mul_done) begin
               tmp_in   = mul_p + (mx_ff >> 1);
               phase_in = 1'b1;
               tneg_in  = 1'b0;
            end else if (phase_ff && !tneg_ff) begin
               ucmd.div_go = 1'b1;
               tneg_in     = 1'b1;
            end else if (phase_ff && div_done) begin
               nv = 67'($signed(st_ff[widx])) +
                    (neg_ff[widx] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q}));
               st_in[widx] = sat_signed(nv[WIDE_W],
                                        nv[WIDE_W] ? WIDE_W'(-nv) : WIDE_W'(nv));
               phase_in = 1'b0;
               tneg_in  = 1'b0;
               state_in = (state_ff == ST_STEP_A) ? ST_STEP_B :
                          (state_ff == ST_STEP_B) ? ST_STEP_C : ST_FK_X;
            end
         end
         // forward kinematics: multiply by circumference, then scale
         ST_FK_X, ST_FK_Y, ST_FK_W: begin
            case (state_ff)
               ST_FK_X: s_num = s0 - s1;
               ST_FK_Y: s_num = s0 + s1 - (s2 <<< 1);
               default: s_num = s0 + s1 + s2;
            endcase
            s_neg = s_num[WIDE_W];
            s_mag = s_neg ? WIDE_W'(-s_num) : WIDE_W'(s_num);
            mul_a = s_mag;
            mul_b = {1'b0, circ_ff};
            if (!phase_ff) begin
               ucmd.mul_go = 1'b1;
               phase_in    = 1'b1;
            end else if (mul_done) begin
               tmp_in   = mul_p;
               tneg_in  = s_neg;
               phase_in = 1'b0;
               state_in = (state_ff == ST_FK_X) ? ST_FK_X2 :
                          (state_ff == ST_FK_Y) ? ST_FK_Y2 : ST_FK_W2;
            end
         end
         // vx: round(p * Kinv / 2^47) as 32-bit halves
         ST_FK_X2: begin
            mul_b = {1'b0, K_INV_SQRT3};
            mul_a = phase_ff ? (tmp_ff >> 32) : {34'd0, tmp_ff[31:0]};
            if (!phase_ff && !spin_neg_ff) begin
               ucmd.mul_go = 1'b1;
               spin_neg_in = 1'b1;
            end else if (!phase_ff && mul_done) begin
               xp_in       = mul_p + (66'd1 << 46);
               phase_in    = 1'b1;
               spin_neg_in = 1'b0;
            end else if (phase_ff && !spin_neg_ff) begin
               ucmd.mul_go = 1'b1;
               spin_neg_in = 1'b1;
            end else if (phase_ff && mul_done) begin
               bo_in[0]    = sat_signed(tneg_ff, (mul_p + (xp_ff >> 32)) >> 15);
               phase_in    = 1'b0;
               spin_neg_in = 1'b0;
               state_in    = ST_FK_Y;
            end
         end
         // vy and omega: rounded divide
         ST_FK_Y2, ST_FK_W2: begin
            if (state_ff == ST_FK_Y2) begin
               div_d = 66'd196608;
               div_n = tmp_ff + 66'd98304;
            end else begin
               div_d = WIDE_W'(rad_ff) * 66'd3;
               div_n = tmp_ff + (div_d >> 1);
            end
            if (state_ff == ST_FK_W2 && rad_ff == '0) begin
               bo_in[2] = (tmp_ff == '0 && (s0 + s1 + s2) == 0) ? '0 :
                          ((s0 + s1 + s2) == 0 ? '0 : sat_signed(tneg_ff, '1));
               state_in = ST_OUT;
            end else if (!phase_ff) begin
               ucmd.div_go = 1'b1;
               phase_in    = 1'b1;
            end else if (div_done) begin
               if (state_ff == ST_FK_Y2) bo_in[1] = sat_signed(tneg_ff, div_q);
               else bo_in[2] = sat_signed(tneg_ff, div_q);
               phase_in = 1'b0;
               state_in = (state_ff == ST_FK_Y2) ? ST_FK_W : ST_OUT;
            end
         end
         // hand the word to the output register
         ST_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in    = 1'b1;
               rd_in    = {bo_ff[2], bo_ff[1], bo_ff[0], st_ff[2], st_ff[1], st_ff[0]};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rv_ff       <= 1'b0;
         phase_ff    <= 1'b0;
         tneg_ff     <= 1'b0;
         spin_neg_ff <= 1'b0;
         st_ff       <= '{default: '0};
      end else begin
         state_ff    <= state_in;
         rv_ff       <= rv_in;
         phase_ff    <= phase_in;
         tneg_ff     <= tneg_in;
         spin_neg_ff <= spin_neg_in;
         st_ff       <= st_in;
      end
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      om_ff     <= om_in;
      cmd_ff    <= cmd_in;
      a_ff      <= a_in;
      neg_ff    <= neg_in;
      spin_ff   <= spin_in;
      xp_ff     <= xp_in;
      xp_neg_ff <= xp_neg_in;
      mx_ff     <= mx_in;
      tmp_ff    <= tmp_in;
      bo_ff     <= bo_in;
      rd_ff     <= rd_in;
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the omni drive kinematics block against an in-bench fixed-point
// predictor of wheel speeds, the change limit and forward kinematics.
// Runs several register settings with directed and random velocity commands.
// ----------------------------------------------------------------------------
module testbench
   import odak_pkg::*;
;

   typedef struct packed {
      logic signed [31:0] omega;
      logic signed [31:0] vy;
      logic signed [31:0] vx;
   } cmd_word_type;

   typedef struct packed {
      logic signed [31:0] bom;
      logic signed [31:0] bvy;
      logic signed [31:0] bvx;
      logic signed [31:0] wc;
      logic signed [31:0] wb;
      logic signed [31:0] wa;
   } drive_word_type;

   localparam longint CYCLE_LIMIT = 4000000;
   localparam int      DRAIN_CYCLES = 1000;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [95:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [191:0]      rsp_tdata;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_AW-1:0] csr_index;
   logic [CFG_W-1:0]  csr_data;

   // predictor state and registers
   bit [63:0]   lim_q, circ_q, rad_q;
   longint      speed_q[3];

   cmd_word_type   cmd_pending[$];
   drive_word_type drive_expected[$];
   int          fail_count;
   int          ticks_sent, ticks_checked, csr_acks;
   longint      cycle_count;
   bit          quiet;

   omni_drive_accel_limited_kinematics dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint sat32(bit neg, bit [63:0] m);
      if (neg) return (m >= 64'h80000000) ? -longint'(64'h80000000) : -longint'(m);
      return (m > 64'h7FFFFFFF) ? longint'(64'h7FFFFFFF) : longint'(m);
   endfunction

   function automatic longint round_shift(longint v, int s);
      bit [63:0] r;
      r = (mag(v) + (64'd1 << (s - 1))) >> s;
      return v < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint div_round_sat(longint num, bit [63:0] den);
      if (den == 0) return (num == 0) ? 0 : sat32(num < 0, '1);
      return sat32(num < 0, (mag(num) + den / 2) / den);
   endfunction

   function automatic bit [63:0] scale_inv_sqrt3(bit [63:0] a);
      bit [63:0] lo, hi, k;
      k  = 64'(K_INV_SQRT3);
      lo = (a & 64'hFFFFFFFF) * k + (64'd1 << 46);
      hi = (a >> 32) * k + (lo >> 32);
      return hi >> 15;
   endfunction

   // advance the stored wheel speeds by one tick and form the response
   function automatic drive_word_type predict_tick(cmd_word_type c);
      longint      vx, vy, om, spin, xpart, half_y, nv;
      longint      cmd[3], d[3];
      bit [63:0]   a[3], mx, st, den;
      longint      dx, sy, sw, bvx, bvy, bom;
      drive_word_type r;
      vx = c.vx;
      vy = c.vy;
      om = c.omega;
      spin   = longint'(rad_q) * om;
      xpart  = round_shift(longint'(K_HALF_SQRT3) * vx, 15);
      half_y = vy * 32768;
      cmd[0] = div_round_sat(half_y + xpart + spin, circ_q);
      cmd[1] = div_round_sat(half_y - xpart + spin, circ_q);
      cmd[2] = div_round_sat(spin - vy * 65536, circ_q);
      for (int i = 0; i < 3; i++) begin
         d[i] = cmd[i] - speed_q[i];
         a[i] = mag(d[i]);
      end
      if (a[0] < lim_q && a[1] < lim_q && a[2] < lim_q) begin
         for (int i = 0; i < 3; i++) speed_q[i] = cmd[i];
      end else begin
         mx = a[0];
         if (a[1] > mx) mx = a[1];
         if (a[2] > mx) mx = a[2];
         if (mx != 0) begin
            for (int i = 0; i < 3; i++) begin
               st = (a[i] * lim_q + mx / 2) / mx;
               nv = speed_q[i] + (d[i] < 0 ? -longint'(st) : longint'(st));
               speed_q[i] = sat32(nv < 0, mag(nv));
            end
         end
      end
      dx  = speed_q[0] - speed_q[1];
      sy  = speed_q[0] + speed_q[1] - 2 * speed_q[2];
      sw  = speed_q[0] + speed_q[1] + speed_q[2];
      bvx = sat32(dx < 0, scale_inv_sqrt3(mag(dx) * circ_q));
      bvy = sat32(sy < 0, (mag(sy) * circ_q + 64'd98304) / 64'd196608);
      if (rad_q == 0) begin
         bom = (sw == 0) ? 0 : sat32(sw < 0, '1);
      end else begin
         den = 3 * rad_q;
         bom = sat32(sw < 0, (mag(sw) * circ_q + den / 2) / den);
      end
      r.wa  = speed_q[0][31:0];
      r.wb  = speed_q[1][31:0];
      r.wc  = speed_q[2][31:0];
      r.bvx = bvx[31:0];
      r.bvy = bvy[31:0];
      r.bom = bom[31:0];
      return r;
   endfunction

   // track register writes
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_DELTA: lim_q  = 64'(csr_data);
            REG_CIRC:      circ_q = 64'(csr_data);
            REG_RADIUS:    rad_q  = 64'(csr_data);
            default: ;
         endcase
         csr_acks <= csr_acks + 1;
      end
   end

   // command driver with random idle bursts
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            drive_expected.push_back(predict_tick(cmd_word_type'(req_tdata)));
            ticks_sent <= ticks_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (cmd_pending.size() > 0) begin
               req_tdata  <= cmd_pending.pop_front();
               req_tvalid <= 1'b1;
               if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 14);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random stall bursts
   int stall_left;
   drive_word_type got, want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = drive_word_type'(rsp_tdata);
            ticks_checked <= ticks_checked + 1;
            if (drive_expected.size() == 0) begin
               $error("unexpected response word %h", rsp_tdata);
               fail_count++;
            end else begin
               want = drive_expected.pop_front();
               if (got.wa !== want.wa) begin
                  $error("wheel_a_rps exp %0d got %0d", want.wa, got.wa); fail_count++;
               end
               if (got.wb !== want.wb) begin
                  $error("wheel_b_rps exp %0d got %0d", want.wb, got.wb); fail_count++;
               end
               if (got.wc !== want.wc) begin
                  $error("wheel_c_rps exp %0d got %0d", want.wc, got.wc); fail_count++;
               end
               if (got.bvx !== want.bvx) begin
                  $error("body_vx exp %0d got %0d", want.bvx, got.bvx); fail_count++;
               end
               if (got.bvy !== want.bvy) begin
                  $error("body_vy exp %0d got %0d", want.bvy, got.bvy); fail_count++;
               end
               if (got.bom !== want.bom) begin
                  $error("body_omega exp %0d got %0d", want.bom, got.bom); fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 13);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_AW-1:0] idx, logic [CFG_W-1:0] val);
      int n;
      n = csr_acks;
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      wait (csr_acks != n);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(logic [CFG_W-1:0] lim, logic [CFG_W-1:0] circ,
                           logic [CFG_W-1:0] rad);
      csr_write(REG_MAX_DELTA, lim);
      csr_write(REG_CIRC, circ);
      csr_write(REG_RADIUS, rad);
   endtask

   // wait for every expected word, then let the sequencer settle
   task automatic drain();
      wait (cmd_pending.size() == 0 && !req_tvalid && drive_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_field();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         2:       return 32'(int'($urandom_range(0, 2 << 16)) - (1 << 16));
         default: return 32'(int'($urandom_range(0, 16 << 16)) - (8 << 16));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_reg(bit allow_zero);
      logic [CFG_W-1:0] v;
      case ($urandom_range(0, 3))
         0:       v = CFG_W'($urandom);
         1:       v = CFG_W'($urandom_range(1, 1 << 12));
         default: v = CFG_W'($urandom_range(1 << 13, 1 << 19));
      endcase
      if (!allow_zero && v == 0) v = 1;
      return v;
   endfunction

   task automatic push_cmd(logic [31:0] vx, logic [31:0] vy, logic [31:0] om);
      cmd_word_type c;
      c.vx = vx;
      c.vy = vy;
      c.omega = om;
      cmd_pending.push_back(c);
   endtask

   task automatic push_random(int n);
      for (int i = 0; i < n; i++) push_cmd(pick_field(), pick_field(), pick_field());
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      fail_count = 0;
      ticks_sent = 0;
      ticks_checked = 0;
      csr_acks = 0;
      cycle_count = 0;
      quiet = 1'b0;
      lim_q = 64'(CFG_RESET);
      circ_q = 64'(CFG_RESET);
      rad_q = 64'(CFG_RESET);
      for (int i = 0; i < 3; i++) speed_q[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset registers, zero command, field extremes
      push_cmd(0, 0, 0);
      push_cmd(32'h00010000, 0, 0);
      push_cmd(0, 32'h00008000, 0);
      push_cmd(0, 0, 32'hFFFF0000);
      push_cmd(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      push_cmd(32'h80000000, 32'h80000000, 32'h80000000);
      push_cmd(32'h7FFFFFFF, 32'h80000000, 0);
      push_cmd(0, 0, 0);
      push_cmd(0, 0, 0);
      push_cmd(32'h00001000, 32'hFFFFF000, 32'h00000800);
      drain();

      // generous limit: commands adopted outright; then saturation
      set_regs(31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF);
      push_cmd(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      push_cmd(32'h80000000, 32'h80000000, 32'h80000000);
      push_cmd(32'h00000001, 32'hFFFFFFFF, 0);
      push_cmd(0, 0, 0);
      push_random(20);
      drain();

      // zero change limit holds the speeds; unit limit with largest sizes
      set_regs(31'd0, 31'h7FFFFFFF, 31'd1);
      push_cmd(32'h00050000, 32'h00030000, 32'h00010000);
      push_random(8);
      drain();
      set_regs(31'd1, 31'h7FFFFFFF, 31'h7FFFFFFF);
      push_random(12);
      drain();

      // random register settings with random commands
      for (int p = 0; p < 11; p++) begin
         set_regs(pick_reg(1), pick_reg(0), pick_reg(0));
         push_random(110);
         drain();
      end

      // closing stretch without idling on either side
      quiet = 1'b1;
      set_regs(31'd65536, 31'd411775, 31'd13107);
      push_random(130);
      drain();

      $display("covered %0d ticks over 16 register settings, incl. zero and full limits",
               ticks_sent);
      $display("checked %0d response words, %0d mismatches", ticks_checked, fail_count);
      if (fail_count == 0 && drive_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
